// ----- rtl/core/crc_pkg.sv -----
// Shared constants for the configurable reflected CRC block.
// No dependencies.
package crc_pkg;

  localparam int DATA_W  = 64;
  localparam int WIDTH_W = 7;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] CFG_CRC_WIDTH     = 2'd0;
  localparam logic [IDX_W-1:0] CFG_POLYNOMIAL    = 2'd1;
  localparam logic [IDX_W-1:0] CFG_INITIAL_VALUE = 2'd2;
  localparam logic [IDX_W-1:0] CFG_FINAL_XOR     = 2'd3;

  localparam logic [WIDTH_W-1:0] RST_CRC_WIDTH     = 7'd32;
  localparam logic [DATA_W-1:0]  RST_POLYNOMIAL    = 64'h0000_0000_04C1_1DB7;
  localparam logic [DATA_W-1:0]  RST_INITIAL_VALUE = 64'h0000_0000_FFFF_FFFF;
  localparam logic [DATA_W-1:0]  RST_FINAL_XOR     = 64'h0000_0000_FFFF_FFFF;
  // Reflected reset initial value over the reset width.
  localparam logic [DATA_W-1:0]  RST_CRC_STATE     = 64'h0000_0000_FFFF_FFFF;

endpackage

// ----- rtl/core/crc_in_if.sv -----
// Request channel carrying message bytes into the CRC block.
// No dependencies.
interface crc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  logic       end_of_message;

  modport source (output valid, data_byte, restart, end_of_message, input ready);
  modport sink (input valid, data_byte, restart, end_of_message, output ready);
endinterface

// ----- rtl/core/crc_out_if.sv -----
// Result channel carrying CRC values out of the CRC block.
// Depends on crc_pkg.
interface crc_out_if;
  import crc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] crc_running;
  logic [DATA_W-1:0] crc_final;
  logic              last;
  logic              valid_res;

  modport source (output valid, crc_running, crc_final, last, valid_res, input ready);
  modport sink (input valid, crc_running, crc_final, last, valid_res, output ready);
endinterface

// ----- rtl/core/configurable_reflected_crc.sv -----
// Top level of the configurable reflected CRC block.
// Depends on crc_pkg, crc_in_if and crc_out_if.
//
// Reflected (LSB-first) CRC over a byte stream, width 1 to MAX_WIDTH bits, with
// polynomial, initial value and final XOR set through the write port. One byte
// is accepted per clock unless the result output stalls. The CRC state memory
// is read into the request stage, bypassed by the write-back of the previous
// byte; results then go to the output register. Polynomial and initial value
// are written in normal bit order and reflected internally in the cycle after
// the write. A zero polynomial or width outside 1..MAX_WIDTH gives valid_res 0,
// zero CRC fields and leaves the state untouched. No clearing pass is needed.
module configurable_reflected_crc #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [crc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [crc_pkg::DATA_W-1:0]    cfg_data,
  crc_in_if.sink                        msg,
  crc_out_if.source                     crc
);
  import crc_pkg::*;

  localparam int MW = MAX_WIDTH;

  logic [WIDTH_W-1:0] crc_width;
  logic [DATA_W-1:0]  polynomial;
  logic [DATA_W-1:0]  initial_value;
  logic [DATA_W-1:0]  final_xor;

  logic          cfg_ok;
  logic [MW-1:0] mask;
  logic [MW-1:0] rpoly;
  logic [MW-1:0] rinit;
  logic [MW-1:0] fxor;

  logic          cfg_ok_next;
  logic [MW-1:0] mask_next;
  logic [MW-1:0] poly_rev;
  logic [MW-1:0] init_rev;
  logic [WIDTH_W-1:0] shamt;

  logic [MW-1:0] crc_mem [1];
  logic          mem_written;
  logic [MW-1:0] rd_data;
  logic          rd_ok;
  logic          byp_hit;
  logic [MW-1:0] byp_data;

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_restart;
  logic          s1_eom;
  logic          s1_adv;
  logic          in_accept;

  logic [MW-1:0] cur;
  logic [MW-1:0] crc_new;
  logic          wr_en;

  logic              out_valid;
  logic [DATA_W-1:0] out_running;
  logic [DATA_W-1:0] out_final;
  logic              out_last;
  logic              out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_width     <= RST_CRC_WIDTH;
      polynomial    <= RST_POLYNOMIAL;
      initial_value <= RST_INITIAL_VALUE;
      final_xor     <= RST_FINAL_XOR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_WIDTH:     crc_width     <= cfg_data[WIDTH_W-1:0];
        CFG_POLYNOMIAL:    polynomial    <= cfg_data;
        CFG_INITIAL_VALUE: initial_value <= cfg_data;
        CFG_FINAL_XOR:     final_xor     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Reflection over the active width: full reverse, then align down.
  always_comb begin
    for (int i = 0; i < MW; i++) begin
      poly_rev[i] = polynomial[MW-1-i];
      init_rev[i] = initial_value[MW-1-i];
    end
    shamt       = WIDTH_W'(MW) - crc_width;
    mask_next   = ~({MW{1'b1}} << crc_width);
    cfg_ok_next = (crc_width != '0) && (crc_width <= WIDTH_W'(MW)) && (polynomial != '0);
  end

  always_ff @(posedge clk) begin
    cfg_ok <= cfg_ok_next;
    mask   <= mask_next;
    rpoly  <= poly_rev >> shamt;
    rinit  <= (init_rev >> shamt) & mask_next;
    fxor   <= final_xor[MW-1:0] & mask_next;
  end

  assign s1_adv    = s1_valid && (!out_valid || crc.ready);
  assign msg.ready = !s1_valid || s1_adv;
  assign in_accept = msg.valid && msg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte    <= msg.data_byte;
      s1_restart <= msg.restart;
      s1_eom     <= msg.end_of_message;
      rd_data    <= crc_mem[0];
      rd_ok      <= mem_written;
      byp_hit    <= wr_en;
      byp_data   <= crc_new;
    end
  end

  always_comb begin
    if (s1_restart) begin
      cur = rinit;
    end else if (byp_hit) begin
      cur = byp_data;
    end else if (rd_ok) begin
      cur = rd_data;
    end else begin
      cur = RST_CRC_STATE[MW-1:0];
    end
    crc_new = (cur & mask) ^ MW'(s1_byte);
    for (int k = 0; k < 8; k++) begin
      crc_new = crc_new[0] ? ((crc_new >> 1) ^ rpoly) : (crc_new >> 1);
    end
    crc_new = crc_new & mask;
  end

  assign wr_en = s1_adv && cfg_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      crc_mem[0] <= crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_written <= 1'b0;
    end else if (wr_en) begin
      mem_written <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (crc.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_last    <= s1_eom;
      out_res     <= cfg_ok;
      out_running <= cfg_ok ? DATA_W'(crc_new) : '0;
      out_final   <= cfg_ok ? DATA_W'(crc_new ^ fxor) : '0;
    end
  end

  assign crc.valid       = out_valid;
  assign crc.crc_running = out_running;
  assign crc.crc_final   = out_final;
  assign crc.last        = out_last;
  assign crc.valid_res   = out_res;

endmodule

// ----- sim/crc_result_check.sv -----
// Result checker for the configurable reflected CRC block: tracks writes and requests,
// predicts each CRC result and compares it with what the block returns.
// Depends on crc_pkg, crc_in_if and crc_out_if.
`timescale 1ns / 100ps

module crc_result_check #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [crc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [crc_pkg::DATA_W-1:0] cfg_data,
  crc_in_if                          msg,
  crc_out_if                         crc,
  output int                         errors,
  output int                         outstanding
);
  import crc_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] crc_running;
    logic [DATA_W-1:0] crc_final;
    logic              last;
    logic              valid_res;
  } crc_result_t;

  logic [WIDTH_W-1:0] cur_width;
  logic [DATA_W-1:0]  cur_poly;
  logic [DATA_W-1:0]  cur_init;
  logic [DATA_W-1:0]  cur_xor;
  logic [DATA_W-1:0]  crc_state;
  crc_result_t        pending_crcs[$];

  function automatic logic [DATA_W-1:0] width_ones(logic [WIDTH_W-1:0] w);
    if (w >= 64)
      return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [DATA_W-1:0] mirror(logic [DATA_W-1:0] x, logic [WIDTH_W-1:0] w);
    logic [DATA_W-1:0] y;
    int i;
    y = '0;
    for (i = 0; i < w && i < 64; i++)
      y = {y[DATA_W-2:0], x[i]};
    return y;
  endfunction

  function automatic crc_result_t advance_crc(logic [7:0] b, logic rs, logic eom);
    crc_result_t       r;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] rp;
    logic [DATA_W-1:0] s;
    int                k;
    r = '0;
    r.last = eom;
    // invalid setup: state held, restart ignored
    if (cur_width == 0 || cur_width > MAX_WIDTH || cur_poly == '0)
      return r;
    m  = width_ones(cur_width);
    rp = mirror(cur_poly, cur_width);
    if (rs)
      crc_state = mirror(cur_init, cur_width);
    s = (crc_state & m) ^ {56'd0, b};
    for (k = 0; k < 8; k++)
      s = s[0] ? ((s >> 1) ^ rp) : (s >> 1);
    s &= m;
    crc_state     = s;
    r.crc_running = s;
    r.crc_final   = (s ^ cur_xor) & m;
    r.valid_res   = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    crc_result_t want;
    if (rst) begin
      cur_width   = RST_CRC_WIDTH;
      cur_poly    = RST_POLYNOMIAL;
      cur_init    = RST_INITIAL_VALUE;
      cur_xor     = RST_FINAL_XOR;
      crc_state   = RST_CRC_STATE;
      pending_crcs.delete();
      errors      = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CRC_WIDTH:     cur_width = cfg_data[WIDTH_W-1:0];
          CFG_POLYNOMIAL:    cur_poly  = cfg_data;
          CFG_INITIAL_VALUE: cur_init  = cfg_data;
          CFG_FINAL_XOR:     cur_xor   = cfg_data;
          default: ;
        endcase
      end
      if (msg.valid && msg.ready)
        pending_crcs.push_back(advance_crc(msg.data_byte, msg.restart, msg.end_of_message));
      if (crc.valid && crc.ready) begin
        if (pending_crcs.size() == 0) begin
          $error("unexpected result: crc_running %h crc_final %h", crc.crc_running,
                 crc.crc_final);
          errors++;
        end else begin
          want = pending_crcs.pop_front();
          if (crc.crc_running !== want.crc_running) begin
            $error("crc_running: expected %h actual %h", want.crc_running, crc.crc_running);
            errors++;
          end
          if (crc.crc_final !== want.crc_final) begin
            $error("crc_final: expected %h actual %h", want.crc_final, crc.crc_final);
            errors++;
          end
          if (crc.last !== want.last) begin
            $error("last: expected %b actual %b", want.last, crc.last);
            errors++;
          end
          if (crc.valid_res !== want.valid_res) begin
            $error("valid_res: expected %b actual %b", want.valid_res, crc.valid_res);
            errors++;
          end
        end
      end
    end
    outstanding = pending_crcs.size();
  end

endmodule

// ----- sim/tb_configurable_reflected_crc.sv -----
// Top of the configurable reflected CRC testbench: clock, reset, register setup,
// byte requests and result back-pressure; verdict from crc_result_check.
// Depends on crc_pkg, crc_in_if, crc_out_if, crc_result_check and the block itself.
`timescale 1ns / 100ps

module tb_configurable_reflected_crc;
  import crc_pkg::*;

  localparam int MAX_WIDTH  = 64;
  localparam int ITEM_COUNT = 1500;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;
  int                errors;
  int                outstanding;
  int                sent;
  bit                no_idle;
  bit                hold_off_due;

  crc_in_if  msg_ch ();
  crc_out_if crc_ch ();

  configurable_reflected_crc #(.MAX_WIDTH(MAX_WIDTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .msg       (msg_ch),
    .crc       (crc_ch)
  );

  crc_result_check #(.MAX_WIDTH(MAX_WIDTH)) result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .msg         (msg_ch),
    .crc         (crc_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic configure(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] p,
                           input logic [DATA_W-1:0] i, input logic [DATA_W-1:0] x);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CRC_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_POLYNOMIAL;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= CFG_INITIAL_VALUE;
    cfg_data  <= i;
    @(posedge clk);
    cfg_index <= CFG_FINAL_XOR;
    cfg_data  <= x;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_req(input logic [7:0] b, input logic rs, input logic eom);
    int g;
    g = no_idle ? 0 : gap_len();
    if (g > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    msg_ch.valid          <= 1'b1;
    msg_ch.data_byte      <= b;
    msg_ch.restart        <= rs;
    msg_ch.end_of_message <= eom;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    sent++;
  endtask

  // drain so that register writes land while the block is idle
  task automatic finish_phase();
    msg_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: random back-pressure plus requested long hold-offs
  initial begin
    int g;
    int n;
    crc_ch.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        crc_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        g = no_idle ? 0 : gap_len();
        if (g > 0) begin
          crc_ch.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        crc_ch.ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] w;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] iv;
    logic [DATA_W-1:0] xv;
    logic [7:0]        b;
    logic              rs;
    logic              eom;
    int                wn;
    int                r;
    int                phase;
    int                phase_items;
    int                len;
    int                k;

    cfg_we                <= 1'b0;
    cfg_index             <= CFG_CRC_WIDTH;
    cfg_data              <= '0;
    msg_ch.valid          <= 1'b0;
    msg_ch.data_byte      <= '0;
    msg_ch.restart        <= 1'b0;
    msg_ch.end_of_message <= 1'b0;
    sent         = 0;
    no_idle      = 1'b0;
    hold_off_due = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // standard CRC-32 check string from reset settings
    for (k = 0; k < 9; k++)
      send_req(8'h31 + k[7:0], k == 0, k == 8);
    finish_phase();

    // full width, all-ones settings
    configure(64'd64, '1, '1, '1);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hFF, 1'b0, 1'b1);
    finish_phase();

    // single-bit CRC
    configure(64'd1, 64'd1, '0, '1);
    send_req(8'hAA, 1'b1, 1'b0);
    send_req(8'h55, 1'b0, 1'b1);
    finish_phase();

    // width change mid-message, register carried over
    configure(64'd16, 64'h8005, '0, '0);
    send_req(8'h3C, 1'b0, 1'b1);
    finish_phase();

    // polynomial only above the width: pure shift
    configure(64'd8, 64'hFFFF_FF00, 64'hFF, '0);
    send_req(8'h81, 1'b1, 1'b0);
    send_req(8'h7E, 1'b0, 1'b1);
    finish_phase();

    // zero polynomial: state held, restart ignored
    configure(64'd32, '0, '1, '1);
    send_req(8'h12, 1'b1, 1'b0);
    send_req(8'hED, 1'b1, 1'b1);
    finish_phase();

    // widths out of range, upper write bits set
    configure({57'h1FF_FFFF_FFFF_FFFF, 7'd0}, 64'h04C1_1DB7, '1, '1);
    send_req(8'hC3, 1'b1, 1'b1);
    finish_phase();
    configure(64'd127, 64'h04C1_1DB7, '1, '1);
    send_req(8'h5A, 1'b0, 1'b0);
    finish_phase();
    configure(64'd65, 64'h04C1_1DB7, '1, '1);
    send_req(8'hA5, 1'b1, 1'b1);
    finish_phase();

    // valid again: the held register continues, then a restart
    configure(64'd32, 64'h1EDC_6F41, '0, '0);
    send_req(8'h96, 1'b0, 1'b0);
    send_req(8'h69, 1'b1, 1'b1);
    finish_phase();

    phase = 0;
    while (sent < ITEM_COUNT) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        wn = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
      else if (r < 40)
        wn = 8 << $urandom_range(0, 3);
      else
        wn = $urandom_range(1, 64);
      w = rand64();
      w[WIDTH_W-1:0] = wn[WIDTH_W-1:0];

      r = $urandom_range(0, 99);
      if (r < 4)
        p = '0;
      else if (r < 8 && wn < 64) begin
        p = rand64() << wn;
        if (p == '0)
          p = 64'd1 << wn;
      end else if (r < 12)
        p = '1;
      else
        p = rand64() | 64'd1;

      r = $urandom_range(0, 99);
      iv = (r < 15) ? '0 : (r < 30) ? '1 : rand64();
      r = $urandom_range(0, 99);
      xv = (r < 15) ? '0 : (r < 30) ? '1 : rand64();

      configure(w, p, iv, xv);
      if (phase == 1 || phase == 9)
        hold_off_due = 1'b1;
      no_idle = ($urandom_range(0, 4) == 0);
      phase_items = $urandom_range(40, 120);

      while (phase_items > 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          b   = 8'($urandom_range(0, 255));
          rs  = (k == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
          eom = (k == len - 1) ? ($urandom_range(0, 9) != 0) : 1'b0;
          if ($urandom_range(0, 9) == 0) begin
            rs  = 1'($urandom_range(0, 1));
            eom = 1'($urandom_range(0, 1));
          end
          send_req(b, rs, eom);
        end
        phase_items -= len;
      end
      finish_phase();
      phase++;
    end

    no_idle = 1'b0;
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
